### sv/assert_macros.svh
// Assertion macros shared by the RTL of the candidate extractor.
// Defining ASSERT_OFF leaves every macro empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("implication check failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### sv/pce_pkg.sv
// Shared constants, types and helper functions of the candidate extractor.
// No dependencies; every other RTL file imports this package.
package pce_pkg;

	// Storage depth of the candidate row and the width of the fill count.
	localparam int MAX_CANDIDATES = 8;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	// Width used when comparing the count against the 4-bit capacity register.
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	// Capacity register after reset.
	localparam logic [3:0] CAP_RESET = 4'd8;

	// Characters the parser looks for.
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [2:0] MARKER_LEN = 3'd6;

	// Token lengths that form a network code, and the saturation point.
	localparam logic [2:0] LEN_FIVE = 3'd5;
	localparam logic [2:0] LEN_SIX = 3'd6;
	localparam logic [2:0] LEN_MAX = 3'd7;

	// Result kinds.
	localparam logic KIND_CAND = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One stored candidate code.
	typedef struct packed {
		logic        six;
		logic [23:0] bcd;
	} pce_entry_t;

	// A token that closed this cycle and qualifies as a network code.
	typedef struct packed {
		logic       valid;
		pce_entry_t entry;
	} pce_token_t;

	// Character expected at each position of the "+COPS:" marker.
	function automatic logic [7:0] marker_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = 8'h2B;
			3'd1: ch = 8'h43;
			3'd2: ch = 8'h4F;
			3'd3: ch = 8'h50;
			3'd4: ch = 8'h53;
			3'd5: ch = 8'h3A;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// True for the ASCII characters '0' to '9'.
	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

endpackage

### sv/pce_parser.sv
// Byte parser of the candidate extractor: marker search, quote pairing and
// token accumulation into packed BCD. Depends on pce_pkg.
module pce_parser import pce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output pce_token_t token
);

	logic [2:0]  mark_q, mark_d;
	logic        quote_q, quote_d;
	logic [2:0]  len_q, len_d;
	logic        digits_q, digits_d;
	logic [23:0] bcd_q, bcd_d;
	logic        mark_done;
	logic        is_quote;

	assign mark_done = (mark_q == MARKER_LEN);
	assign is_quote = (text_byte == CHAR_QUOTE);

	// A closing quote on a token of five or six digits reports a code.
	always_comb begin
		token.valid = mark_done && is_quote && quote_q && digits_q &&
			((len_q == LEN_FIVE) || (len_q == LEN_SIX));
		token.entry.six = (len_q == LEN_SIX);
		token.entry.bcd = bcd_q;
	end

	// Next state for one accepted byte.
	always_comb begin
		mark_d = mark_q;
		quote_d = quote_q;
		len_d = len_q;
		digits_d = digits_q;
		bcd_d = bcd_q;
		if (!mark_done) begin
			if (text_byte == marker_char(mark_q)) begin
				mark_d = mark_q + 3'd1;
			end else begin
				mark_d = (text_byte == CHAR_PLUS) ? 3'd1 : 3'd0;
			end
		end else if (is_quote) begin
			if (!quote_q) begin
				quote_d = 1'b1;
				len_d = 3'd0;
				digits_d = 1'b1;
				bcd_d = '0;
			end else begin
				quote_d = 1'b0;
			end
		end else if (quote_q) begin
			if (is_digit(text_byte)) begin
				// The first digit lands in the top nibble.
				for (int k = 0; k < 6; k++) begin
					if (len_q == 3'(k)) begin
						bcd_d[4 * (5 - k) +: 4] = text_byte[3:0];
					end
				end
			end else begin
				digits_d = 1'b0;
			end
			if (len_q != LEN_MAX) begin
				len_d = len_q + 3'd1;
			end
		end
		// The last byte of a response returns the parser to its initial state.
		if (end_of_text) begin
			mark_d = 3'd0;
			quote_d = 1'b0;
			len_d = 3'd0;
			digits_d = 1'b1;
			bcd_d = '0;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 3'd0;
			quote_q <= 1'b0;
			len_q <= 3'd0;
			digits_q <= 1'b1;
			bcd_q <= '0;
		end else if (accept) begin
			mark_q <= mark_d;
			quote_q <= quote_d;
			len_q <= len_d;
			digits_q <= digits_d;
			bcd_q <= bcd_d;
		end
	end

endmodule

### sv/pce_cell.sv
// One storage cell of the candidate row: holds a code, shifts it to the
// next cell on a store and adds its own match to the hit chain. Depends on pce_pkg.
module pce_cell import pce_pkg::*; (
	input  logic             clk,
	input  logic             shift_en,
	input  pce_entry_t       entry_in,
	input  pce_entry_t       probe,
	input  logic [CNT_W-1:0] cell_index,
	input  logic [CNT_W-1:0] count,
	input  logic             hit_in,
	output pce_entry_t       entry_out,
	output logic             hit_out
);

	pce_entry_t entry_q;
	logic       occupied;

	// Cell zero holds the newest code, so only the first count cells are live.
	assign occupied = (cell_index < count);

	// Hit chain across the row.
	assign hit_out = hit_in || (occupied && (entry_q == probe));
	assign entry_out = entry_q;

	// Shift register stage.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= entry_in;
		end
	end

endmodule

### sv/plmn_candidate_extractor.sv
// Top level of the network code candidate extractor: parser, candidate row
// and output register. Depends on pce_pkg, pce_parser, pce_cell and assert_macros.svh.
`include "assert_macros.svh"

// Takes one response byte per cycle and registers its result as the byte
// is accepted. A closed code is checked against every held code along the row of
// storage cells in the cycle it arrives, and a new code shifts into the row head.
// The output register holds one result; when a byte produces both a candidate and
// the end summary, the next byte waits while the summary goes out.
// Otherwise a byte is taken every cycle as long as the output side does not stall.
// The capacity write port is always ready and should be used between responses.
module plmn_candidate_extractor import pce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [2:0]  slot,
	output logic [23:0] code_bcd,
	output logic [2:0]  code_digits,
	output logic [3:0]  total,
	output logic        last
);

	logic [3:0]       capacity_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             in_accept;
	logic             out_take;
	logic             pend_q;
	logic [3:0]       pend_total_q;
	logic             out_valid_q;
	pce_token_t       token;
	pce_entry_t       entry_link [0:MAX_CANDIDATES];
	logic             hit_link [0:MAX_CANDIDATES];
	logic             room;
	logic             store;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// A byte is taken unless the output register cannot drain in time.
	assign in_stall = out_valid_q && (out_stall || pend_q);
	assign in_accept = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;

	pce_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.token       (token)
	);

	// Candidate row; cell zero takes the incoming code.
	assign entry_link[0] = token.entry;
	assign hit_link[0] = 1'b0;
	for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
		pce_cell u_cell (
			.clk        (clk),
			.shift_en   (store),
			.entry_in   (entry_link[i]),
			.probe      (token.entry),
			.cell_index (CNT_W'(i)),
			.count      (count_q),
			.hit_in     (hit_link[i]),
			.entry_out  (entry_link[i + 1]),
			.hit_out    (hit_link[i + 1])
		);
	end

	// Store a qualifying code not already held while below both the capacity and the row depth.
	assign room = (CMP_W'(count_q) < CMP_W'(capacity_q)) &&
		(CMP_W'(count_q) < CMP_W'(MAX_CANDIDATES));
	assign store = in_accept && token.valid && room && !hit_link[MAX_CANDIDATES];
	assign count_next = store ? count_q + CNT_W'(1) : count_q;

	// Fill count, cleared by the last byte of a response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_accept) begin
			count_q <= end_of_text ? '0 : count_next;
		end
	end

	// Output register with one pending summary behind a candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (in_accept && (store || end_of_text)) begin
			out_valid_q <= 1'b1;
			pend_q <= store && end_of_text;
		end else if (out_take) begin
			out_valid_q <= pend_q;
			pend_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_take && pend_q) begin
			kind <= KIND_SUMMARY;
			slot <= 3'd0;
			code_bcd <= '0;
			code_digits <= 3'd0;
			total <= pend_total_q;
			last <= 1'b1;
		end
		if (in_accept && store) begin
			kind <= KIND_CAND;
			slot <= 3'(count_q);
			code_bcd <= token.entry.bcd;
			code_digits <= token.entry.six ? LEN_SIX : LEN_FIVE;
			total <= 4'(count_next);
			last <= !end_of_text;
			pend_total_q <= 4'(count_next);
		end else if (in_accept && end_of_text) begin
			kind <= KIND_SUMMARY;
			slot <= 3'd0;
			code_bcd <= '0;
			code_digits <= 3'd0;
			total <= 4'(count_q);
			last <= 1'b1;
		end
	end

	`ASSERT_IMPLIES(a_pend_has_head, clk, arst_n, pend_q, (out_valid_q && kind == KIND_CAND))
	`ASSERT_NEVER(a_count_bound, clk, arst_n, (CMP_W'(count_q) > CMP_W'(MAX_CANDIDATES)))
	`ASSERT_IMPLIES(a_end_clears, clk, arst_n, (in_accept && end_of_text), ##1 (count_q == '0))
	`ASSERT_IMPLIES(a_pend_blocks, clk, arst_n, pend_q, in_stall)

endmodule
